FILE: sv/gtq_pkg.sv
// Shared types, codes and helpers for the grouped timer queue.
package gtq_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int TIME_W = 48;
   localparam int AMT_W = 32;
   localparam int GRP_W = 8;
   localparam int TAG_W = 16;
   localparam int REP_W = 16;
   localparam int ORD_W = 16;
   localparam int SLOTF_W = 4;

   // Request codes.
   localparam logic [3:0] OP_TICK = 4'd0;
   localparam logic [3:0] OP_SCHED = 4'd1;
   localparam logic [3:0] OP_CANCEL_ALL = 4'd2;
   localparam logic [3:0] OP_CANCEL_GRP = 4'd3;
   localparam logic [3:0] OP_DELAY_ALL = 4'd4;
   localparam logic [3:0] OP_DELAY_GRP = 4'd5;
   localparam logic [3:0] OP_RESCHED_ALL = 4'd6;
   localparam logic [3:0] OP_RESCHED_GRP = 4'd7;
   localparam logic [3:0] OP_REPEAT = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_FIRED = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;
   localparam logic [1:0] KIND_NOT_FIRED = 2'd3;

   typedef struct packed {
      logic [3:0]         req_type;
      logic [AMT_W-1:0]   amount_ms;
      logic [GRP_W-1:0]   group_id;
      logic               has_group;
      logic [TAG_W-1:0]   task_tag;
      logic [SLOTF_W-1:0] slot_sel;
      logic               use_base;
      logic [TIME_W-1:0]  base_time;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [SLOTF_W-1:0] slot;
      logic [TAG_W-1:0]   tag;
      logic [REP_W-1:0]   repeat_count;
      logic [TIME_W-1:0]  fire_time;
      logic               last;
   } rsp_payload_type;

   // One stored timer entry.
   typedef struct packed {
      logic [TIME_W-1:0] end_time;
      logic [AMT_W-1:0]  period;
      logic [GRP_W-1:0]  group;
      logic              grouped;
      logic [REP_W-1:0]  repeats;
      logic [TAG_W-1:0]  tag;
      logic [ORD_W-1:0]  order;
   } entry_type;

   typedef enum logic [1:0] {
      SLOT_ZERO,
      SLOT_BEST,
      SLOT_SEL
   } slot_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         cap;
      logic         scan_clr;
      logic         scan_rd;
      logic         rd_sel;
      logic         act_fire;
      logic         act_modify;
      logic         act_sched;
      logic         act_repeat;
      logic         emit;
      logic [1:0]   emit_kind;
      slot_src_type emit_slot;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] op;
      logic       scan_last;
      logic       found;
      logic       sel_ok;
      logic       out_free;
   } status_type;

   // Add a duration to a time, saturating at the largest time.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [AMT_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W + 1 - AMT_W){1'b0}}, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

FILE: sv/gtq_datapath.sv
// Datapath: entry memory, slot flags, scan and selection, time and output register.
module gtq_datapath
   import gtq_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  cmd_type         cmd,
   output status_type      status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SW = (AW > SLOTF_W) ? AW : SLOTF_W;

   entry_type entry_mem [NUM_SLOTS];
   entry_type rd_ff;

   req_payload_type rq_ff, rq_in;
   logic [TIME_W-1:0] cur_ff, cur_in;
   logic [ORD_W-1:0] ord_ff, ord_in, snap_ff, snap_in;
   logic [NUM_SLOTS-1:0] pend_ff, pend_in, fired_ff, fired_in, touched_ff, touched_in;
   logic [AW-1:0] addr_ff, addr_in, pidx_ff;
   logic pv_ff;
   entry_type best_ff, best_in;
   logic [AW-1:0] bslot_ff, bslot_in;
   logic found_ff, found_in, ffree_ff, ffree_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [SW-1:0] sel_ext, bslot_ext;
   logic [AW-1:0] sel_idx;
   logic sel_ok;
   logic out_free;

   // Slot index conversions between the 4-bit fields and the table index.
   assign sel_ext = SW'(rq_ff.slot_sel);
   assign sel_idx = sel_ext[AW-1:0];
   assign bslot_ext = SW'(bslot_ff);
   assign sel_ok = (32'(sel_ext) < 32'(NUM_SLOTS)) && fired_ff[sel_idx];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.op = rq_ff.req_type;
   assign status.scan_last = (addr_ff == AW'(NUM_SLOTS - 1));
   assign status.found = found_ff;
   assign status.sel_ok = sel_ok;
   assign status.out_free = out_free;

   // Scope and ordering of the entry read in the previous cycle.
   logic [3:0] op;
   logic grp_only, is_cancel, is_modify, resched, in_scope, ahead, cand;
   logic [ORD_W-1:0] age_rd, age_best;
   logic pend_i, fired_i;

   always_comb begin
      op = rq_ff.req_type;
      grp_only = (op == OP_CANCEL_GRP) || (op == OP_DELAY_GRP) || (op == OP_RESCHED_GRP);
      is_cancel = (op == OP_CANCEL_ALL) || (op == OP_CANCEL_GRP);
      is_modify = (op == OP_DELAY_ALL) || (op == OP_DELAY_GRP) ||
                  (op == OP_RESCHED_ALL) || (op == OP_RESCHED_GRP);
      resched = (op == OP_RESCHED_ALL) || (op == OP_RESCHED_GRP);
      pend_i = pend_ff[pidx_ff];
      fired_i = fired_ff[pidx_ff];
      in_scope = pend_i && (!grp_only ||
                 (rd_ff.grouped && (rd_ff.group == rq_ff.group_id)));
      age_rd = snap_ff - rd_ff.order;
      age_best = snap_ff - best_ff.order;
      ahead = (rd_ff.end_time < best_ff.end_time) ||
              ((rd_ff.end_time == best_ff.end_time) && (age_rd > age_best));
      if (op == OP_TICK) begin
         cand = pend_i && (rd_ff.end_time <= cur_ff);
      end else if (is_modify) begin
         cand = in_scope && !touched_ff[pidx_ff];
      end else begin
         cand = 1'b0;
      end
   end

   // One shared adder for the entry end times written back.
   logic [TIME_W-1:0] add_a, new_end;
   logic [AMT_W-1:0] add_b;
   entry_type wr_rec;
   logic [AW-1:0] wr_idx;
   logic wr_en;

   always_comb begin
      add_a = best_ff.end_time;
      add_b = rq_ff.amount_ms;
      if (cmd.act_modify && resched) begin
         add_a = cur_ff;
      end else if (cmd.act_sched) begin
         add_a = rq_ff.use_base ? rq_ff.base_time : cur_ff;
      end else if (cmd.act_repeat) begin
         add_a = rd_ff.end_time;
         add_b = rd_ff.period;
      end
      new_end = sat_add(add_a, add_b);

      wr_en = cmd.act_modify || cmd.act_sched || cmd.act_repeat;
      wr_idx = cmd.act_repeat ? sel_idx : bslot_ff;
      wr_rec = best_ff;
      if (cmd.act_sched) begin
         wr_rec.period = rq_ff.amount_ms;
         wr_rec.group = rq_ff.group_id;
         wr_rec.grouped = rq_ff.has_group;
         wr_rec.repeats = '0;
         wr_rec.tag = rq_ff.task_tag;
      end else if (cmd.act_repeat) begin
         wr_rec = rd_ff;
         if (rd_ff.repeats != {REP_W{1'b1}}) begin
            wr_rec.repeats = rd_ff.repeats + 1'b1;
         end
      end
      wr_rec.end_time = new_end;
      wr_rec.order = ord_ff;
   end

   // Entry memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_rec;
      end
      if (cmd.scan_rd || cmd.rd_sel) begin
         rd_ff <= entry_mem[cmd.rd_sel ? sel_idx : addr_ff];
      end
   end

   // Request capture, time, stamp counter and slot flags.
   always_comb begin
      rq_in = rq_ff;
      cur_in = cur_ff;
      snap_in = snap_ff;
      touched_in = touched_ff;
      ord_in = ord_ff;
      pend_in = pend_ff;
      fired_in = fired_ff;
      if (cmd.cap) begin
         rq_in = req_data;
         snap_in = ord_ff;
         touched_in = '0;
         if (req_data.req_type == OP_TICK) begin
            cur_in = sat_add(cur_ff, req_data.amount_ms);
         end
      end
      if (wr_en) begin
         ord_in = ord_ff + 1'b1;
      end
      if (pv_ff && is_cancel && in_scope) begin
         pend_in[pidx_ff] = 1'b0;
      end
      if (cmd.act_fire) begin
         pend_in[bslot_ff] = 1'b0;
         fired_in[bslot_ff] = 1'b1;
      end
      if (cmd.act_modify) begin
         touched_in[bslot_ff] = 1'b1;
      end
      if (cmd.act_sched) begin
         pend_in[bslot_ff] = 1'b1;
         fired_in[bslot_ff] = 1'b0;
      end
      if (cmd.act_repeat) begin
         pend_in[sel_idx] = 1'b1;
         fired_in[sel_idx] = 1'b0;
      end
   end

   // Scan address and running selection.
   always_comb begin
      addr_in = addr_ff;
      best_in = best_ff;
      bslot_in = bslot_ff;
      found_in = found_ff;
      ffree_in = ffree_ff;
      if (cmd.scan_clr) begin
         addr_in = '0;
         found_in = 1'b0;
         ffree_in = 1'b0;
      end else if (cmd.scan_rd) begin
         addr_in = addr_ff + 1'b1;
      end
      if (pv_ff) begin
         if (op == OP_SCHED) begin
            // Lowest free slot wins, else the lowest slot that is not pending.
            if (!pend_i && !fired_i && !ffree_ff) begin
               bslot_in = pidx_ff;
               found_in = 1'b1;
               ffree_in = 1'b1;
            end else if (!pend_i && !found_ff) begin
               bslot_in = pidx_ff;
               found_in = 1'b1;
            end
         end else if (cand && (!found_ff || ahead)) begin
            best_in = rd_ff;
            bslot_in = pidx_ff;
            found_in = 1'b1;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.kind = cmd.emit_kind;
         case (cmd.emit_slot)
            SLOT_BEST: rsp_in.slot = bslot_ext[SLOTF_W-1:0];
            SLOT_SEL:  rsp_in.slot = rq_ff.slot_sel;
            default:   rsp_in.slot = '0;
         endcase
         if (cmd.emit_kind == KIND_FIRED) begin
            rsp_in.tag = best_ff.tag;
            rsp_in.repeat_count = best_ff.repeats;
            rsp_in.fire_time = best_ff.end_time;
            rsp_in.last = 1'b0;
         end else begin
            rsp_in.tag = '0;
            rsp_in.repeat_count = '0;
            rsp_in.fire_time = cur_ff;
            rsp_in.last = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         ord_ff <= '0;
         pend_ff <= '0;
         fired_ff <= '0;
         pv_ff <= 1'b0;
         found_ff <= 1'b0;
         ffree_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         ord_ff <= ord_in;
         pend_ff <= pend_in;
         fired_ff <= fired_in;
         pv_ff <= cmd.scan_rd;
         found_ff <= found_in;
         ffree_ff <= ffree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rq_ff <= rq_in;
      snap_ff <= snap_in;
      touched_ff <= touched_in;
      addr_ff <= addr_in;
      pidx_ff <= addr_ff;
      best_ff <= best_in;
      bslot_ff <= bslot_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: sv/gtq_ctrl.sv
// Controller: sequences scans, selections, updates and results for each item.
module gtq_ctrl
   import gtq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [3:0] req_op,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_FIRE,
      ST_MODIFY,
      ST_SCHED,
      ST_REP_RD,
      ST_REP_CHK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] fin_kind_ff, fin_kind_in;
   slot_src_type fin_slot_ff, fin_slot_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      fin_kind_in = fin_kind_ff;
      fin_slot_in = fin_slot_ff;
      cmd = '0;
      cmd.emit_kind = KIND_DONE;
      cmd.emit_slot = SLOT_ZERO;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap = 1'b1;
               fin_kind_in = KIND_DONE;
               fin_slot_in = SLOT_ZERO;
               case (req_op)
                  OP_TICK, OP_SCHED, OP_CANCEL_ALL, OP_CANCEL_GRP, OP_DELAY_ALL,
                  OP_DELAY_GRP, OP_RESCHED_ALL, OP_RESCHED_GRP: begin
                     cmd.scan_clr = 1'b1;
                     state_in = ST_SCAN;
                  end
                  OP_REPEAT: state_in = ST_REP_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: state_in = ST_DECIDE;
         ST_DECIDE: begin
            case (status.op)
               OP_TICK: state_in = status.found ? ST_FIRE : ST_DONE;
               OP_SCHED: begin
                  if (status.found) begin
                     fin_slot_in = SLOT_BEST;
                     state_in = ST_SCHED;
                  end else begin
                     fin_kind_in = KIND_FULL;
                     state_in = ST_DONE;
                  end
               end
               OP_DELAY_ALL, OP_DELAY_GRP, OP_RESCHED_ALL, OP_RESCHED_GRP:
                  state_in = status.found ? ST_MODIFY : ST_DONE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_FIRE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = KIND_FIRED;
               cmd.emit_slot = SLOT_BEST;
               cmd.act_fire = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_MODIFY: begin
            cmd.act_modify = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCHED: begin
            cmd.act_sched = 1'b1;
            state_in = ST_DONE;
         end
         ST_REP_RD: begin
            cmd.rd_sel = 1'b1;
            state_in = ST_REP_CHK;
         end
         ST_REP_CHK: begin
            fin_slot_in = SLOT_SEL;
            if (status.sel_ok) begin
               cmd.act_repeat = 1'b1;
            end else begin
               fin_kind_in = KIND_NOT_FIRED;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_kind = fin_kind_ff;
               cmd.emit_slot = fin_slot_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered result selection.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_kind_ff <= KIND_DONE;
         fin_slot_ff <= SLOT_ZERO;
      end else begin
         state_ff <= state_in;
         fin_kind_ff <= fin_kind_in;
         fin_slot_ff <= fin_slot_in;
      end
   end

endmodule

FILE: sv/grouped_timer_queue_core.sv
// Top level of the grouped timer queue: controller plus datapath.
//
// Requests arrive on the req_ channel (valid/ready) as one packed item and
// results leave on the rsp_ channel (valid/ready). Every request gives one
// result with last set; a tick first gives one fired result per expired
// entry, in end-time order with ties in queue order, then its done result.
// Items are handled one at a time. Each selection reads the entry memory
// once per slot, and a decision step follows each scan. The final result
// is offered in the cycle after it is loaded, when a new item can be
// taken. The entry memory has a single read port. The result register
// lets a new item be taken while the last result waits; a stalled
// receiver holds the block only when it has another result to give.
// Synchronous reset clears time, the stamp counter and all pending and
// fired flags; the entry memory needs no clearing.
module grouped_timer_queue_core
   import gtq_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   cmd_type cmd;
   status_type status;

   // Sequencing.
   gtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   gtq_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/gtq_checker.sv
// Port checker for the grouped timer queue and its bind to the top level.
module gtq_checker
   import gtq_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A result held back by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Nothing is offered straight after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only fired entries leave without the final mark.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_FIRED) != rsp_data.last))
      else $error("last flag does not match result kind");

   // Results other than fired entries carry no tag or repeat count.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_FIRED) |->
         (rsp_data.tag == '0) && (rsp_data.repeat_count == '0))
      else $error("non-fired result carries entry data");

   // Items are taken one at a time, so the input is busy after each one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after taking an item");

endmodule

bind grouped_timer_queue_core gtq_checker u_gtq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/tb_grouped_timer_queue_core.sv
// Self-checking testbench for the grouped timer queue core.
`timescale 1ns / 1ps

module tb_grouped_timer_queue_core;
   import gtq_pkg::*;

   localparam int NSLOT = 16;
   localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
   localparam int CYCLE_LIMIT = 900000;
   localparam logic [3:0] OP_UNKNOWN = 4'd12;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   grouped_timer_queue_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the timer table.
   logic [47:0] now_ms;
   logic [15:0] stamp_next;
   logic        pend [NSLOT];
   logic        fired [NSLOT];
   logic [47:0] end_ms [NSLOT];
   logic [31:0] period_ms [NSLOT];
   logic [7:0]  grp [NSLOT];
   logic        grouped [NSLOT];
   logic [15:0] reps [NSLOT];
   logic [15:0] htag [NSLOT];
   logic [15:0] stamp [NSLOT];

   rsp_payload_type expected_rsps[$];
   int  errors = 0;
   int  rsp_count = 0;
   int  fired_count = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp = 1'b0;

   // Saturating 48-bit addition of a 32-bit amount.
   function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? TMAX : s[47:0];
   endfunction

   // True when slot a comes ahead of slot b in queue order.
   function automatic bit ahead_of(int a, int b);
      logic [15:0] age_a, age_b;
      age_a = stamp_next - stamp[a];
      age_b = stamp_next - stamp[b];
      if (end_ms[a] != end_ms[b]) return end_ms[a] < end_ms[b];
      return age_a > age_b;
   endfunction

   // Sorts the slots in lst into queue order, in place.
   task automatic queue_order(ref int lst[$]);
      int v, j;
      for (int i = 1; i < lst.size(); i++) begin
         v = lst[i];
         j = i - 1;
         while (j >= 0 && ahead_of(v, lst[j])) begin
            lst[j + 1] = lst[j];
            j--;
         end
         lst[j + 1] = v;
      end
   endtask

   task automatic add_result(logic [1:0] kind, int slot, logic [15:0] tg,
                             logic [15:0] rc, logic [47:0] t, bit lst);
      rsp_payload_type r;
      r.kind = kind; r.slot = slot[3:0]; r.tag = tg; r.repeat_count = rc;
      r.fire_time = t; r.last = lst;
      expected_rsps.push_back(r);
   endtask

   // Works out the results of one request and updates the shadow table.
   task automatic predict_timer_results(req_payload_type q);
      int lst[$];
      int pick;
      logic [47:0] nend;
      case (q.req_type)
         OP_TICK: begin
            now_ms = add_sat(now_ms, q.amount_ms);
            for (int s = 0; s < NSLOT; s++)
               if (pend[s] && end_ms[s] <= now_ms) lst.push_back(s);
            queue_order(lst);
            foreach (lst[i]) begin
               pend[lst[i]] = 1'b0;
               fired[lst[i]] = 1'b1;
               add_result(KIND_FIRED, lst[i], htag[lst[i]], reps[lst[i]],
                          end_ms[lst[i]], 1'b0);
               fired_count++;
            end
            add_result(KIND_DONE, 0, '0, '0, now_ms, 1'b1);
         end
         OP_SCHED: begin
            pick = -1;
            for (int s = 0; s < NSLOT; s++)
               if (pick < 0 && !pend[s] && !fired[s]) pick = s;
            for (int s = 0; s < NSLOT; s++)
               if (pick < 0 && !pend[s]) pick = s;
            if (pick < 0) begin
               add_result(KIND_FULL, 0, '0, '0, now_ms, 1'b1);
            end else begin
               pend[pick] = 1'b1; fired[pick] = 1'b0;
               end_ms[pick] = add_sat(q.use_base ? q.base_time : now_ms, q.amount_ms);
               period_ms[pick] = q.amount_ms;
               grp[pick] = q.group_id; grouped[pick] = q.has_group;
               reps[pick] = '0; htag[pick] = q.task_tag;
               stamp[pick] = stamp_next; stamp_next++;
               add_result(KIND_DONE, pick, '0, '0, now_ms, 1'b1);
            end
         end
         OP_CANCEL_ALL, OP_CANCEL_GRP: begin
            for (int s = 0; s < NSLOT; s++)
               if (pend[s] && (q.req_type == OP_CANCEL_ALL ||
                               (grouped[s] && grp[s] == q.group_id)))
                  pend[s] = 1'b0;
            add_result(KIND_DONE, 0, '0, '0, now_ms, 1'b1);
         end
         OP_DELAY_ALL, OP_DELAY_GRP, OP_RESCHED_ALL, OP_RESCHED_GRP: begin
            nend = add_sat(now_ms, q.amount_ms);
            for (int s = 0; s < NSLOT; s++)
               if (pend[s] && ((q.req_type == OP_DELAY_ALL ||
                                q.req_type == OP_RESCHED_ALL) ||
                               (grouped[s] && grp[s] == q.group_id)))
                  lst.push_back(s);
            queue_order(lst);
            foreach (lst[i]) begin
               end_ms[lst[i]] = (q.req_type >= OP_RESCHED_ALL) ? nend
                                : add_sat(end_ms[lst[i]], q.amount_ms);
               stamp[lst[i]] = stamp_next; stamp_next++;
            end
            add_result(KIND_DONE, 0, '0, '0, now_ms, 1'b1);
         end
         OP_REPEAT: begin
            if (!fired[q.slot_sel]) begin
               add_result(KIND_NOT_FIRED, q.slot_sel, '0, '0, now_ms, 1'b1);
            end else begin
               end_ms[q.slot_sel] = add_sat(end_ms[q.slot_sel], period_ms[q.slot_sel]);
               if (reps[q.slot_sel] != 16'hFFFF) reps[q.slot_sel]++;
               fired[q.slot_sel] = 1'b0; pend[q.slot_sel] = 1'b1;
               stamp[q.slot_sel] = stamp_next; stamp_next++;
               add_result(KIND_DONE, q.slot_sel, '0, '0, now_ms, 1'b1);
            end
         end
         default: add_result(KIND_DONE, 0, '0, '0, now_ms, 1'b1);
      endcase
   endtask

   // Sends one item, idling first at random, and predicts its results.
   task automatic send_item(req_payload_type q);
      if (idle_on) begin
         while ($urandom_range(99) < 16) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_results(q);
      req_valid <= 1'b0;
      // The block is busy in the cycle after it takes an item.
      @(posedge clock);
   endtask

   function automatic req_payload_type rand_item();
      req_payload_type q;
      q.req_type  = 4'($urandom_range(15));
      q.amount_ms = $urandom;
      q.group_id  = 8'($urandom);
      q.has_group = 1'($urandom);
      q.task_tag  = 16'($urandom);
      q.slot_sel  = 4'($urandom);
      q.use_base  = 1'($urandom);
      q.base_time = 48'({$urandom, $urandom});
      return q;
   endfunction

   function automatic req_payload_type mk(logic [3:0] op, logic [31:0] amt,
                                          logic [7:0] g = 8'd0, bit hg = 1'b0);
      req_payload_type q;
      q = rand_item();
      q.req_type = op; q.amount_ms = amt; q.group_id = g; q.has_group = hg;
      q.use_base = 1'b0;
      return q;
   endfunction

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Directed: extremes, all request codes but delay-all and reschedule-all, full table and repeat errors.
   task automatic test_directed();
      req_payload_type q;
      send_item(mk(OP_REPEAT, 0));
      for (int i = 0; i < 17; i++) begin
         q = mk(OP_SCHED, 32'(i % 3), 8'(i % 2), i[0]);
         q.task_tag = (i == 0) ? 16'hFFFF : 16'(i);
         send_item(q);
      end
      send_item(mk(OP_DELAY_GRP, 5, 8'd1, 1'b1));
      send_item(mk(OP_TICK, 3));
      send_item(mk(OP_RESCHED_GRP, 0, 8'd0, 1'b1));
      q = mk(OP_REPEAT, 0); q.slot_sel = 4'hF; send_item(q);
      send_item(mk(OP_TICK, 32'hFFFF_FFFF));
      send_item(mk(OP_UNKNOWN, 1));
      send_item(mk(OP_CANCEL_GRP, 0, 8'd0, 1'b1));
      send_item(mk(OP_CANCEL_ALL, 0));
      wait_drained();
   endtask

   // Sends a random burst of schedules, ticks, repeats, modifications and cancels, with some fully random items.
   task automatic test_random(int n);
      req_payload_type q;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         q = rand_item();
         q.amount_ms = $urandom_range(40);
         q.group_id = 8'($urandom_range(3));
         if (r < 10) q = rand_item();
         else if (r < 35) q.req_type = OP_SCHED;
         else if (r < 60) q.req_type = OP_TICK;
         else if (r < 75) q.req_type = OP_REPEAT;
         else q.req_type = 4'($urandom_range(OP_CANCEL_ALL, OP_RESCHED_GRP));
         if (q.req_type == OP_SCHED && q.use_base)
            q.base_time = now_ms + 48'($urandom_range(20));
         if (q.req_type == OP_CANCEL_ALL && $urandom_range(3) != 0) q.req_type = OP_TICK;
         send_item(q);
      end
   endtask

   // Receiver holds off while items are sent, until the hold is released; then a full drain.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      test_random(30);
      hold_rsp = 1'b0;
      wait_drained();
   endtask

   task automatic test_saturation();
      req_payload_type q;
      q = mk(OP_SCHED, 32'hFFFF_FFFF); q.use_base = 1'b1; q.base_time = TMAX;
      send_item(q);
      for (int i = 0; i < 4; i++) send_item(mk(OP_TICK, 32'hFFFF_FFFF));
      for (int i = 0; i < 70000; i++) begin
         q = mk(OP_REPEAT, 0); q.slot_sel = 0;
         predict_only_repeat: begin
            send_item(q);
            send_item(mk(OP_TICK, 0));
         end
         if (i == 3) break;
      end
      wait_drained();
   endtask

   // Receiver side: random stalls, a long hold on request, and checking.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $realtime, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: expected %p actual %p", $realtime,
                           expected_rsps[0], rsp_data);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         rsp_ready <= hold_rsp ? 1'b0 : (!idle_on || $urandom_range(99) >= 16);
      end
   end

   // Hold-off counted in cycles: releases after a long stretch.
   initial begin
      int held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) held++;
         if (held > 400) hold_rsp = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      now_ms = '0; stamp_next = '0;
      for (int s = 0; s < NSLOT; s++) begin
         pend[s] = 1'b0; fired[s] = 1'b0; end_ms[s] = '0; period_ms[s] = '0;
         grp[s] = '0; grouped[s] = 1'b0; reps[s] = '0; htag[s] = '0; stamp[s] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      idle_on = 1'b0;
      test_random(60);
      idle_on = 1'b1;
      wait_drained();
      test_random(150);
      test_saturation();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered directed extremes, full table, back-pressure and random traffic:");
      $display("%0d results checked, %0d timer firings, %0d errors",
               rsp_count, fired_count, errors);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
